[src/mte_pkg.sv]
// package for the multipartite table evaluator
// holds field widths, parameter defaults, command and register codes, config type
// no dependencies
`timescale 1ns / 1ps

package mte_pkg;

   // parameter defaults
   localparam int IN_BITS_DEF           = 16;
   localparam int NUM_OFFSET_TABLES_DEF = 4;
   localparam int MAX_ALPHA_DEF         = 12;
   localparam int OFFSET_ADDR_BITS_DEF  = 10;
   localparam int WORD_BITS_DEF         = 32;
   localparam int OUT_BITS_DEF          = 16;

   // beat field widths
   localparam int CMD_W   = 2;
   localparam int TSEL_W  = 2;
   localparam int EADDR_W = 12;
   localparam int EVAL_W  = 32;
   localparam int X_W     = 16;

   // config port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NIB_W      = 4;
   localparam int SHIFT_W    = 5;
   localparam int CNT_W      = NIB_W + 1;
   localparam int POS_W      = 6;
   localparam int SLICE_W    = 16;
   localparam int GUARD_MAX  = (1 << NIB_W) - 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_EVAL     = 2'd0,
      CMD_WR_MAIN  = 2'd1,
      CMD_WR_SUB   = 2'd2,
      CMD_WR_OFF   = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPRESS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_BITS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_SHIFT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NEG_MASK   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_PACK  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_PACK = 3'd7;

   typedef struct packed {
      logic [NIB_W-1:0]      alpha;
      logic [NIB_W-1:0]      guard_bits;
      logic                  compress_enable;
      logic [NIB_W-1:0]      subsample_index_bits;
      logic [SHIFT_W-1:0]    subsample_shift;
      logic [NIB_W-1:0]      negative_mask;
      logic [CSR_DATA_W-1:0] beta_pack;
      logic [CSR_DATA_W-1:0] gamma_pack;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      alpha:                4'd8,
      guard_bits:           4'd2,
      compress_enable:      1'b0,
      subsample_index_bits: 4'd4,
      subsample_shift:      5'd0,
      negative_mask:        4'd0,
      beta_pack:            16'h4444,
      gamma_pack:           16'h4444
   };

endpackage

[src/multipartite_table_evaluator_top.sv]
// top level of the multipartite table evaluator
// depends on mte_pkg, mte_ram, mte_addr and mte_sum
`timescale 1ns / 1ps

// Usage
// - command channel: a beat is taken at a clock edge with start high and busy low;
//   req_cmd selects evaluate, main table write, subsample table write or offset
//   table write (req_table_index picks the bank, req_entry_address the entry)
// - evaluate beats give one result beat, marked by rsp_valid for one cycle;
//   write beats give none
// - rsp_valid rises once the beat has passed the stage 1 capture, the registered
//   table reads and the two adder stages; one beat per cycle is taken while
//   busy is low
// - busy is set by reset and cleared by the first edge with reset low
// - results cannot be held off by the receiver; rsp_valid/rsp_y_out appear
//   for one cycle only
// - the csr port writes a register at any edge with csr_we high; write it only
//   when no evaluate is in flight
// - reset sets the registers to their defaults and empties the pipeline;
//   table contents are undefined until written
// - a table write is seen by every evaluate beat accepted after it

module multipartite_table_evaluator_top #(
   parameter int IN_BITS           = mte_pkg::IN_BITS_DEF,
   parameter int NUM_OFFSET_TABLES = mte_pkg::NUM_OFFSET_TABLES_DEF,
   parameter int MAX_ALPHA         = mte_pkg::MAX_ALPHA_DEF,
   parameter int OFFSET_ADDR_BITS  = mte_pkg::OFFSET_ADDR_BITS_DEF,
   parameter int WORD_BITS         = mte_pkg::WORD_BITS_DEF,
   parameter int OUT_BITS          = mte_pkg::OUT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mte_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mte_pkg::TSEL_W-1:0]          req_table_index,
   input  logic [mte_pkg::EADDR_W-1:0]         req_entry_address,
   input  logic signed [mte_pkg::EVAL_W-1:0]   req_entry_value,
   input  logic [mte_pkg::X_W-1:0]             req_x_in,
   output logic                                rsp_valid,
   output logic [OUT_BITS-1:0]                 rsp_y_out,
   input  logic                                csr_we,
   input  logic [mte_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mte_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import mte_pkg::*;

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA:      cfg_in.alpha                = csr_wdata[NIB_W-1:0];
            CSR_GUARD:      cfg_in.guard_bits           = csr_wdata[NIB_W-1:0];
            CSR_COMPRESS:   cfg_in.compress_enable      = csr_wdata[0];
            CSR_SUB_BITS:   cfg_in.subsample_index_bits = csr_wdata[NIB_W-1:0];
            CSR_SUB_SHIFT:  cfg_in.subsample_shift      = csr_wdata[SHIFT_W-1:0];
            CSR_NEG_MASK:   cfg_in.negative_mask        = csr_wdata[NIB_W-1:0];
            CSR_BETA_PACK:  cfg_in.beta_pack            = csr_wdata;
            CSR_GAMMA_PACK: cfg_in.gamma_pack           = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // busy is set by reset and cleared by the first edge with reset low
   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   // stage 1: captured command beat
   logic                  v1_ff;
   cmd_type               cmd1_ff;
   logic [TSEL_W-1:0]     tsel1_ff;
   logic [EADDR_W-1:0]    addr1_ff;
   logic [WORD_BITS-1:0]  value1_ff;
   logic [IN_BITS-1:0]    x1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd1_ff   <= cmd_type'(req_cmd);
         tsel1_ff  <= req_table_index;
         addr1_ff  <= req_entry_address;
         value1_ff <= WORD_BITS'(req_entry_value);   // two's complement reduce/extend
         x1_ff     <= IN_BITS'(req_x_in);
      end
   end

   // address generation from the captured argument
   logic [MAX_ALPHA-1:0]         main_addr;
   logic [MAX_ALPHA-1:0]         sub_addr;
   logic [OFFSET_ADDR_BITS-1:0]  off_addr [NUM_OFFSET_TABLES];
   logic [NUM_OFFSET_TABLES-1:0] off_flip;
   logic [NUM_OFFSET_TABLES-1:0] off_en;

   mte_addr #(
      .IN_BITS           (IN_BITS),
      .NUM_OFFSET_TABLES (NUM_OFFSET_TABLES),
      .MAX_ALPHA         (MAX_ALPHA),
      .OFFSET_ADDR_BITS  (OFFSET_ADDR_BITS)
   ) u_addr (
      .x         (x1_ff),
      .cfg       (cfg_ff),
      .main_addr (main_addr),
      .sub_addr  (sub_addr),
      .off_addr  (off_addr),
      .off_flip  (off_flip),
      .off_en    (off_en)
   );

   // tables: writes and reads both happen at stage 1, so beat order is kept
   logic                 main_we;
   logic                 sub_we;
   logic [WORD_BITS-1:0] main_word;
   logic [WORD_BITS-1:0] sub_word;
   logic [WORD_BITS-1:0] off_word [NUM_OFFSET_TABLES];

   assign main_we = v1_ff && (cmd1_ff == CMD_WR_MAIN);
   assign sub_we  = v1_ff && (cmd1_ff == CMD_WR_SUB);

   mte_ram #(
      .WIDTH     (WORD_BITS),
      .ADDR_BITS (MAX_ALPHA)
   ) u_main_ram (
      .clock (clock),
      .we    (main_we),
      .waddr (MAX_ALPHA'(addr1_ff)),
      .wdata (value1_ff),
      .raddr (main_addr),
      .rdata (main_word)
   );

   mte_ram #(
      .WIDTH     (WORD_BITS),
      .ADDR_BITS (MAX_ALPHA)
   ) u_sub_ram (
      .clock (clock),
      .we    (sub_we),
      .waddr (MAX_ALPHA'(addr1_ff)),
      .wdata (value1_ff),
      .raddr (sub_addr),
      .rdata (sub_word)
   );

   // one bank per offset table; writes to an absent bank fall away
   for (genvar i = 0; i < NUM_OFFSET_TABLES; i++) begin : g_bank
      logic off_we;

      assign off_we = v1_ff && (cmd1_ff == CMD_WR_OFF) && (tsel1_ff == TSEL_W'(i));

      mte_ram #(
         .WIDTH     (WORD_BITS),
         .ADDR_BITS (OFFSET_ADDR_BITS)
      ) u_off_ram (
         .clock (clock),
         .we    (off_we),
         .waddr (OFFSET_ADDR_BITS'(addr1_ff)),
         .wdata (value1_ff),
         .raddr (off_addr[i]),
         .rdata (off_word[i])
      );
   end

   // stage 2: sign/fold controls aligned with the read data
   logic                         v2_ff;
   logic [NUM_OFFSET_TABLES-1:0] flip2_ff;
   logic [NUM_OFFSET_TABLES-1:0] en2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff && (cmd1_ff == CMD_EVAL);
      end
   end

   always_ff @(posedge clock) begin
      flip2_ff <= off_flip;
      en2_ff   <= off_en;
   end

   // stages 3 and 4: adder and guard bit drop
   mte_sum #(
      .WORD_BITS         (WORD_BITS),
      .NUM_OFFSET_TABLES (NUM_OFFSET_TABLES),
      .OUT_BITS          (OUT_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .cfg       (cfg_ff),
      .main_word (main_word),
      .sub_word  (sub_word),
      .off_word  (off_word),
      .off_flip  (flip2_ff),
      .off_en    (en2_ff),
      .out_valid (rsp_valid),
      .y         (rsp_y_out)
   );

   // every evaluate beat yields a result
   a_eval_result : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_EVAL)) |-> ##4 rsp_valid)
      else $error("evaluate beat without result");

   // write beats never yield a result
   a_write_silent : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd != CMD_EVAL)) |-> ##4 !rsp_valid)
      else $error("result from a write beat");

   // no result without a matching evaluate beat
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && (req_cmd == CMD_EVAL), 4))
      else $error("result without evaluate beat");

   // busy only follows reset
   a_busy_reset : assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(reset))
      else $error("busy outside reset recovery");

endmodule

[src/mte_ram.sv]
// simple dual port table memory, one write and one registered read per cycle
// depends on mte_pkg for default widths
`timescale 1ns / 1ps

module mte_ram #(
   parameter int WIDTH     = mte_pkg::WORD_BITS_DEF,
   parameter int ADDR_BITS = mte_pkg::OFFSET_ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [2**ADDR_BITS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/mte_addr.sv]
// address generation: main and subsample addresses, folded offset table indexes
// depends on mte_pkg for the config type and field widths
`timescale 1ns / 1ps

module mte_addr #(
   parameter int IN_BITS           = mte_pkg::IN_BITS_DEF,
   parameter int NUM_OFFSET_TABLES = mte_pkg::NUM_OFFSET_TABLES_DEF,
   parameter int MAX_ALPHA         = mte_pkg::MAX_ALPHA_DEF,
   parameter int OFFSET_ADDR_BITS  = mte_pkg::OFFSET_ADDR_BITS_DEF
) (
   input  logic [IN_BITS-1:0]           x,
   input  mte_pkg::cfg_type             cfg,
   output logic [MAX_ALPHA-1:0]         main_addr,
   output logic [MAX_ALPHA-1:0]         sub_addr,
   output logic [OFFSET_ADDR_BITS-1:0]  off_addr [NUM_OFFSET_TABLES],
   output logic [NUM_OFFSET_TABLES-1:0] off_flip,
   output logic [NUM_OFFSET_TABLES-1:0] off_en
);

   import mte_pkg::*;

   localparam int LIM = (MAX_ALPHA < IN_BITS) ? MAX_ALPHA : IN_BITS;
   localparam int XE  = IN_BITS + 16;
   localparam logic [CNT_W-1:0] LIM_V     = CNT_W'(LIM);
   localparam logic [CNT_W-1:0] IN_BITS_C = CNT_W'(IN_BITS);
   localparam logic [POS_W-1:0] IN_BITS_V = POS_W'(IN_BITS);

   logic [XE-1:0]    x_ext;
   logic [CNT_W-1:0] a_bits;
   logic [CNT_W-1:0] s_bits;
   logic [POS_W-1:0] pos [NUM_OFFSET_TABLES+1];

   assign x_ext = XE'(x);

   // saturate address widths at the usable input top
   assign a_bits = ({1'b0, cfg.alpha} > LIM_V) ? LIM_V : {1'b0, cfg.alpha};
   assign s_bits = ({1'b0, cfg.subsample_index_bits} > LIM_V) ? LIM_V
                 : {1'b0, cfg.subsample_index_bits};

   assign main_addr = MAX_ALPHA'(x_ext >> (IN_BITS_V - POS_W'(a_bits)));
   assign sub_addr  = MAX_ALPHA'(x_ext >> (IN_BITS_V - POS_W'(s_bits)));

   // slice positions are running sums of the beta widths
   always_comb begin
      pos[0] = '0;
      for (int i = 0; i < NUM_OFFSET_TABLES; i++) begin
         pos[i+1] = pos[i] + POS_W'(cfg.beta_pack[NIB_W*i +: NIB_W]);
      end
   end

   for (genvar i = 0; i < NUM_OFFSET_TABLES; i++) begin : g_off
      logic [NIB_W-1:0]            b;
      logic [NIB_W-1:0]            bm1;
      logic [CNT_W-1:0]            g;
      logic [SLICE_W-1:0]          slice;
      logic [SLICE_W-1:0]          half;
      logic                        top;
      logic [OFFSET_ADDR_BITS-1:0] lo;
      logic [OFFSET_ADDR_BITS-1:0] hi;

      assign b     = cfg.beta_pack[NIB_W*i +: NIB_W];
      assign bm1   = b - NIB_W'(1);
      assign g     = ({1'b0, cfg.gamma_pack[NIB_W*i +: NIB_W]} > IN_BITS_C) ? IN_BITS_C
                   : {1'b0, cfg.gamma_pack[NIB_W*i +: NIB_W]};
      assign slice = SLICE_W'(x_ext >> pos[i]) & ((SLICE_W'(1) << b) - SLICE_W'(1));
      assign half  = (SLICE_W'(1) << bm1) - SLICE_W'(1);
      assign top   = slice[bm1];
      // symmetric fold: lower half of the slice mirrored when its top bit is clear
      assign lo    = OFFSET_ADDR_BITS'((slice & half) ^ (top ? '0 : half));
      assign hi    = OFFSET_ADDR_BITS'((x_ext >> (IN_BITS_V - POS_W'(g))) << bm1);

      assign off_addr[i] = lo | hi;
      assign off_flip[i] = ~top ^ cfg.negative_mask[i];
      assign off_en[i]   = (b != '0);
   end

endmodule

[src/mte_sum.sv]
// two-stage adder: initial value plus offset terms, guard bit drop
// depends on mte_pkg for the config type
`timescale 1ns / 1ps

module mte_sum #(
   parameter int WORD_BITS         = mte_pkg::WORD_BITS_DEF,
   parameter int NUM_OFFSET_TABLES = mte_pkg::NUM_OFFSET_TABLES_DEF,
   parameter int OUT_BITS          = mte_pkg::OUT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  mte_pkg::cfg_type             cfg,
   input  logic [WORD_BITS-1:0]         main_word,
   input  logic [WORD_BITS-1:0]         sub_word,
   input  logic [WORD_BITS-1:0]         off_word [NUM_OFFSET_TABLES],
   input  logic [NUM_OFFSET_TABLES-1:0] off_flip,
   input  logic [NUM_OFFSET_TABLES-1:0] off_en,
   output logic                         out_valid,
   output logic [OUT_BITS-1:0]          y
);

   import mte_pkg::*;

   localparam int SUM_W = OUT_BITS + GUARD_MAX;
   localparam int EXT_W = (SUM_W > WORD_BITS) ? SUM_W : WORD_BITS;

   logic [SUM_W-1:0]    main_ext;
   logic [SUM_W-1:0]    sub_ext;
   logic [SUM_W-1:0]    base_in;
   logic [SUM_W-1:0]    off_in;
   logic [SUM_W-1:0]    total;
   logic [SUM_W-1:0]    base_ff;
   logic [SUM_W-1:0]    off_ff;
   logic                valid_a_ff;
   logic                valid_b_ff;
   logic [OUT_BITS-1:0] y_ff;

   assign main_ext = SUM_W'(EXT_W'($signed(main_word)));
   assign sub_ext  = SUM_W'(EXT_W'($signed(sub_word)));
   assign base_in  = main_ext + (cfg.compress_enable ? (sub_ext << cfg.subsample_shift) : '0);

   always_comb begin
      off_in = '0;
      for (int i = 0; i < NUM_OFFSET_TABLES; i++) begin
         if (off_en[i]) begin
            off_in = off_in + (off_flip[i] ? ~SUM_W'(EXT_W'($signed(off_word[i])))
                                           : SUM_W'(EXT_W'($signed(off_word[i]))));
         end
      end
   end

   assign total = base_ff + off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      off_ff  <= off_in;
      y_ff    <= OUT_BITS'(total >> cfg.guard_bits);
   end

   assign out_valid = valid_b_ff;
   assign y         = y_ff;

endmodule
